// File: rtl/core/tron_pkg.sv
// shared types, byte codes and constants of the telnet receive option negotiator
package tron_pkg;

	localparam logic [1:0] TERM_COUNT = 2'd2;

	localparam int QUEUE_AW = 2;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	localparam logic [7:0] B_IAC = 8'd255;
	localparam logic [7:0] B_DONT = 8'd254;
	localparam logic [7:0] B_DO = 8'd253;
	localparam logic [7:0] B_WONT = 8'd252;
	localparam logic [7:0] B_WILL = 8'd251;
	localparam logic [7:0] B_SB = 8'd250;
	localparam logic [7:0] B_SE = 8'd240;
	localparam logic [7:0] B_ESC = 8'd27;
	localparam logic [7:0] B_NUL = 8'd0;
	localparam logic [7:0] ESC_FINAL_ABOVE = 8'd64;
	localparam logic [7:0] OPT_ECHO = 8'd1;
	localparam logic [7:0] OPT_SUPP = 8'd3;
	localparam logic [7:0] OPT_TERM = 8'd24;
	localparam logic [7:0] TT_SEND = 8'd1;
	localparam logic [7:0] TT_IS = 8'd0;

	localparam logic [1:0] JOB_BYTE = 2'd0;
	localparam logic [1:0] JOB_REPLY = 2'd1;
	localparam logic [1:0] JOB_TERM = 2'd2;

	localparam logic OUT_HOST = 1'b0;
	localparam logic OUT_PEER = 1'b1;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] b0;
		logic [7:0] b1;
	} job_t;

	typedef struct packed {
		logic push;
		logic full;
		logic pop;
		logic empty;
	} queue_ctl_t;

endpackage

// File: rtl/core/tron_in_if.sv
// request channel carrying received telnet bytes
interface tron_in_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// File: rtl/core/tron_out_if.sv
// request channel carrying host payload bytes and peer reply bytes
interface tron_out_if;
	logic valid;
	logic ready;
	logic out_kind;
	logic [7:0] out_byte;
	logic out_last;

	modport source (output valid, output out_kind, output out_byte, output out_last,
		input ready);
	modport sink (input valid, input out_kind, input out_byte, input out_last,
		output ready);
endinterface

// File: rtl/core/tron_front.sv
// front end: iac parser, payload handlers and option decisions, emits jobs
module tron_front import tron_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] rx_byte,
	output logic       push,
	output job_t       push_job
);

	localparam logic [1:0] PH_DATA = 2'd0;
	localparam logic [1:0] PH_CMD = 2'd1;
	localparam logic [1:0] PH_OPT = 2'd2;

	localparam logic [2:0] V_SB = 3'd0;
	localparam logic [2:0] V_WILL = 3'd1;
	localparam logic [2:0] V_WONT = 3'd2;
	localparam logic [2:0] V_DO = 3'd3;
	localparam logic [2:0] V_DONT = 3'd4;

	localparam logic [1:0] H_NVT = 2'd0;
	localparam logic [1:0] H_ANSI = 2'd1;
	localparam logic [1:0] H_TERMSB = 2'd2;
	localparam logic [1:0] H_NONE = 2'd3;

	localparam logic [1:0] E_NORMAL = 2'd0;
	localparam logic [1:0] E_AFTER = 2'd1;
	localparam logic [1:0] E_INSIDE = 2'd2;

	logic [1:0] phase_q, phase_d;
	logic [2:0] verb_q, verb_d;
	logic [1:0] handler_q, handler_d;
	logic [1:0] esc_q, esc_d;
	logic [1:0] choice_q, choice_d;
	logic       deliver;
	logic       has_job;
	job_t       job;
	logic [7:0] verb_full;

	function automatic logic clamp(logic [1:0] c);
		logic [1:0] r;
		r = (c >= TERM_COUNT) ? (TERM_COUNT - 2'd1) : c;
		return r[0];
	endfunction

	assign verb_full = rx_byte - B_SB;

	always_comb begin
		phase_d = phase_q;
		verb_d = verb_q;
		handler_d = handler_q;
		esc_d = esc_q;
		choice_d = choice_q;
		deliver = 1'b0;
		has_job = 1'b0;
		job = '{kind: JOB_BYTE, b0: rx_byte, b1: rx_byte};

		case (phase_q)
			PH_CMD: begin
				phase_d = PH_DATA;
				if (rx_byte == B_IAC) begin
					deliver = 1'b1;
				end else if (rx_byte == B_SE) begin
					handler_d = clamp(choice_q) ? H_ANSI : H_NVT;
				end else if (rx_byte >= B_SB) begin
					verb_d = verb_full[2:0];
					phase_d = PH_OPT;
				end
			end
			PH_OPT: begin
				phase_d = PH_DATA;
				if (verb_q == V_SB || verb_q > V_DONT) begin
					handler_d = (rx_byte == OPT_TERM) ? H_TERMSB : H_NONE;
				end else if (rx_byte == OPT_ECHO) begin
					has_job = 1'b1;
					job.kind = JOB_REPLY;
					if (verb_q == V_WILL) job.b0 = B_DO;
					else if (verb_q == V_WONT) job.b0 = B_DONT;
					else job.b0 = B_WONT;
				end else if (rx_byte == OPT_SUPP) begin
					has_job = 1'b0;
				end else if (rx_byte == OPT_TERM) begin
					job.kind = JOB_REPLY;
					if (verb_q == V_WILL) begin
						has_job = 1'b1;
						job.b0 = B_DONT;
					end else if (verb_q == V_DO) begin
						has_job = 1'b1;
						job.b0 = B_WILL;
					end
				end else begin
					job.kind = JOB_REPLY;
					if (verb_q == V_WILL) begin
						has_job = 1'b1;
						job.b0 = B_DONT;
					end else if (verb_q == V_DO) begin
						has_job = 1'b1;
						job.b0 = B_WONT;
					end
				end
			end
			default: begin
				phase_d = PH_DATA;
				if (rx_byte == B_IAC) phase_d = PH_CMD;
				else deliver = 1'b1;
			end
		endcase

		if (deliver) begin
			case (handler_q)
				H_NVT: begin
					has_job = (rx_byte != B_NUL);
				end
				H_ANSI: begin
					if (esc_q == E_AFTER) begin
						esc_d = E_INSIDE;
					end else if (esc_q == E_INSIDE) begin
						if (rx_byte > ESC_FINAL_ABOVE) esc_d = E_NORMAL;
					end else begin
						esc_d = E_NORMAL;
						if (rx_byte == B_ESC) esc_d = E_AFTER;
						else has_job = (rx_byte != B_NUL);
					end
				end
				H_TERMSB: begin
					if (rx_byte == TT_SEND) begin
						choice_d = (choice_q == TERM_COUNT) ? 2'd0 : choice_q + 2'd1;
						has_job = 1'b1;
						job.kind = JOB_TERM;
						job.b0 = {7'd0, clamp(choice_d)};
					end
				end
				default: begin
					has_job = 1'b0;
				end
			endcase
		end
	end

	assign push = accept && has_job;
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DATA;
			verb_q <= V_SB;
			handler_q <= H_NVT;
			esc_q <= E_NORMAL;
			choice_q <= 2'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			verb_q <= verb_d;
			handler_q <= handler_d;
			esc_q <= esc_d;
			choice_q <= choice_d;
		end
	end

endmodule

// File: rtl/core/tron_queue.sv
// short job queue between the parser and the output sequencer
module tron_queue import tron_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  job_t       push_job,
	input  logic       pop,
	output job_t       head,
	output queue_ctl_t ctl
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q, rd_q;
	logic [QUEUE_AW:0]   count_q;
	logic                full, empty;

	assign full = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head = mem_q[rd_q];
	assign ctl = '{push: push, full: full, pop: pop, empty: empty};

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full || pop)
		else $error("job pushed into a full queue");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("job popped from an empty queue");

endmodule

// File: rtl/core/tron_back.sv
// back end: expands queued jobs into result bytes through an output register
module tron_back import tron_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head,
	input  logic       empty,
	output logic       pop,
	output logic       valid,
	input  logic       ready,
	output logic       out_kind,
	output logic [7:0] out_byte,
	output logic       out_last
);

	logic [3:0] step_q;
	logic       valid_q;
	logic       kind_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       advance;
	logic       load;
	logic [7:0] item_byte;
	logic       item_last;
	logic       item_kind;

	function automatic logic [7:0] name_char(logic idx, logic [3:0] pos);
		logic [7:0] c;
		c = 8'd0;
		if (!idx) begin
			case (pos)
				4'd0: c = 8'd78;
				4'd1: c = 8'd86;
				4'd2: c = 8'd84;
				default: c = 8'd0;
			endcase
		end else begin
			case (pos)
				4'd0: c = 8'd65;
				4'd1: c = 8'd78;
				4'd2: c = 8'd83;
				4'd3: c = 8'd73;
				default: c = 8'd0;
			endcase
		end
		return c;
	endfunction

	always_comb begin
		logic [3:0] nlen;
		nlen = head.b0[0] ? 4'd4 : 4'd3;
		item_kind = OUT_PEER;
		item_byte = head.b0;
		item_last = 1'b0;
		case (head.kind)
			JOB_BYTE: begin
				item_kind = OUT_HOST;
				item_byte = head.b0;
				item_last = 1'b1;
			end
			JOB_REPLY: begin
				case (step_q)
					4'd0: item_byte = B_IAC;
					4'd1: item_byte = head.b0;
					default: item_byte = head.b1;
				endcase
				item_last = (step_q >= 4'd2);
			end
			default: begin
				if (step_q == 4'd0) item_byte = B_IAC;
				else if (step_q == 4'd1) item_byte = B_SB;
				else if (step_q == 4'd2) item_byte = OPT_TERM;
				else if (step_q == 4'd3) item_byte = TT_IS;
				else if (step_q < nlen + 4'd4) item_byte = name_char(head.b0[0], step_q - 4'd4);
				else if (step_q == nlen + 4'd4) item_byte = B_IAC;
				else item_byte = B_SE;
				item_last = (step_q >= nlen + 4'd5);
			end
		endcase
	end

	assign advance = !valid_q || ready;
	assign load = advance && !empty;
	assign pop = load && item_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q <= 4'd0;
		end else if (advance) begin
			valid_q <= !empty;
			if (load) step_q <= item_last ? 4'd0 : step_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= item_kind;
			byte_q <= item_byte;
			last_q <= item_last;
		end
	end

	assign valid = valid_q;
	assign out_kind = kind_q;
	assign out_byte = byte_q;
	assign out_last = last_q;

	assert property (@(posedge clk) disable iff (!arst_n) step_q != 4'd0 |-> !empty)
		else $error("sequencer mid job with no job queued");
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && head.kind == JOB_REPLY |-> step_q < 4'd3)
		else $error("reply job ran past three bytes");
	assert property (@(posedge clk) disable iff (!arst_n)
		load && item_kind == OUT_HOST |-> item_last && step_q == 4'd0)
		else $error("host byte not a single last item");

endmodule

// File: rtl/core/telnet_rx_option_negotiator.sv
// top level of the telnet receive option negotiator
// channels: rx takes one received telnet byte per request (rx_byte); result
// gives one item per request: out_kind 0 is a payload byte for the host,
// 1 a byte to send back to the peer, out_last marks the final item that one
// received byte causes. bytes that cause nothing give no item.
// throughput: one received byte per cycle while the job queue is not full;
// a host byte gives one result item, an option reply three, a terminal-type
// answer nine or ten, one item per cycle from the sequencer while result.ready
// is high. path: the first result of a byte is written into the job queue and
// then loaded into the output register, when the queue is empty and the output is free.
// a four-entry job queue sits between the parser and the sequencer; rx.ready
// drops only when that queue is full.
// reset: arst_n clears the parser to the data phase, the verb to SB, the
// handler to NVT, the escape state and terminal choice to zero, and empties
// the queue and output register.
// when the receiver holds result.ready low the output item holds, the
// sequencer waits, and the parser keeps taking bytes until the queue fills.
module telnet_rx_option_negotiator import tron_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	tron_in_if.sink    rx,
	tron_out_if.source result
);

	logic       accept;
	logic       push;
	job_t       push_job;
	job_t       head;
	logic       pop;
	queue_ctl_t qctl;

	assign rx.ready = !qctl.full;
	assign accept = rx.valid && rx.ready;

	tron_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (rx.rx_byte),
		.push     (push),
		.push_job (push_job)
	);

	tron_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.ctl      (qctl)
	);

	tron_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (qctl.empty),
		.pop      (pop),
		.valid    (result.valid),
		.ready    (result.ready),
		.out_kind (result.out_kind),
		.out_byte (result.out_byte),
		.out_last (result.out_last)
	);

endmodule
